/* rtl/core/bscg_pkg.sv */
// Shared constants, types and lookup tables for the coulomb-counting fuel gauge.
// Holds the fixed-point step constants, the reciprocal for the step divider and
// the 21-bin open-circuit voltage / series resistance tables. No dependencies.
package bscg_pkg;

    // State of charge, signed Q2.30
    localparam int unsigned       SOC_W   = 32;
    localparam logic signed [31:0] Q_ONE   = 32'sh4000_0000;
    localparam logic signed [31:0] SOC_MIN = 32'sh8000_0000;
    // accumulator width: soc plus a step of up to 2^32
    localparam int unsigned       ACW     = 35;

    // elapsed time: values at or above the gap limit count as zero
    localparam logic [15:0]       GAP_LIMIT = 16'd100;
    localparam int unsigned       DT_W      = 7;

    // seconds mode scales the step numerator by 1000 onto the ms divisor
    localparam int unsigned       SCALE_MS  = 1000;

    // Step quotient q = floor(y * 2^30 / 1.08e10) = floor(y * 2^20 / 10546875).
    // y saturates at 4 * 1.08e10, which gives q = 2^32 and always saturates soc.
    localparam int unsigned       YW      = 36;
    localparam int unsigned       YH      = YW / 2;
    localparam logic [YW-1:0]     Y_CAP   = 36'd43200000000;
    localparam int unsigned       REM_SH  = 20;
    localparam int unsigned       DW      = 24;
    localparam logic [DW-1:0]     DIV_D   = 24'd10546875;
    localparam int unsigned       RCW     = 33;
    localparam int unsigned       DIV_SH  = YW;
    localparam logic [RCW-1:0]    DIV_M   = RCW'((64'd1 << (DIV_SH + REM_SH)) / 64'd10546875);
    localparam int unsigned       PPW     = YH + RCW;
    localparam int unsigned       FW      = YW + RCW;
    localparam int unsigned       QW      = 33;
    // remainder lies in [0, 2*D) and fits 25 bits
    localparam int unsigned       RW      = 25;
    localparam int unsigned       YLW     = RW - REM_SH;

    // bin tables
    localparam int unsigned       BIN_COUNT = 21;
    localparam int unsigned       BIN_W     = 5;
    typedef logic [BIN_W-1:0] bin_idx_t;
    typedef logic [14:0]      table_val_t;
    localparam bin_idx_t          BIN_LAST  = bin_idx_t'(BIN_COUNT - 1);
    localparam table_val_t        VOC_RESET = 15'd15000;
    localparam table_val_t        RS_RESET  = 15'd18500;

    // configuration register index (word address)
    localparam logic [0:0]        REG_TIME_IN_MS = 1'b0;

    function automatic table_val_t voc_of(bin_idx_t b);
        case (b)
            5'd0:    return 15'd15000;
            5'd1:    return 15'd17721;
            5'd2:    return 15'd18612;
            5'd3:    return 15'd19371;
            5'd4:    return 15'd20015;
            5'd5:    return 15'd20389;
            5'd6:    return 15'd20704;
            5'd7:    return 15'd20968;
            5'd8:    return 15'd21225;
            5'd9:    return 15'd21562;
            5'd10:   return 15'd21892;
            5'd11:   return 15'd22202;
            5'd12:   return 15'd22477;
            5'd13:   return 15'd22750;
            5'd14:   return 15'd22995;
            5'd15:   return 15'd23315;
            5'd16:   return 15'd23617;
            5'd17:   return 15'd23834;
            5'd18:   return 15'd23894;
            5'd19:   return 15'd24067;
            default: return 15'd25200;
        endcase
    endfunction

    function automatic table_val_t rs_of(bin_idx_t b);
        case (b)
            5'd0:    return 15'd18500;
            5'd1:    return 15'd18500;
            5'd2:    return 15'd16700;
            5'd3:    return 15'd16500;
            5'd4:    return 15'd18200;
            5'd5:    return 15'd18000;
            5'd6:    return 15'd18700;
            5'd7:    return 15'd18800;
            5'd8:    return 15'd19100;
            5'd9:    return 15'd20300;
            5'd10:   return 15'd21400;
            5'd11:   return 15'd22400;
            5'd12:   return 15'd22800;
            5'd13:   return 15'd23400;
            5'd14:   return 15'd23600;
            5'd15:   return 15'd24600;
            5'd16:   return 15'd25700;
            5'd17:   return 15'd25600;
            5'd18:   return 15'd24300;
            default: return 15'd23900;
        endcase
    endfunction

endpackage

/* rtl/core/battery_soc_coulomb_gauge_core.sv */
// Coulomb-counting battery fuel gauge, top level.
// Depends on bscg_pkg (constants, divider reciprocal, bin tables).
//
// Usage:
//   s_ channel: one item per handshake, a current sample in mA (negative means
//   charging) and the elapsed time since the previous sample. Elapsed values of
//   100 or more count as zero.
//   m_ channel: one item per input item, in order: state of charge (signed
//   Q2.30, clamped at 1.0 and -2.0), open-circuit voltage (mV), series resistance (uOhm)
//   and a depletion flag. While soc is below zero, voltage and resistance hold.
//   APB port: register 0 (byte address 0) bit 0 selects milliseconds (1) or
//   seconds (0) for the elapsed field. Write it only while the gauge is idle.
// Pipeline: 10 stages; an accepted item passes the registers of stages 0 to 9 in
//   order before m_valid rises. Throughput: one item per cycle while the output
//   is not stalled (m_ready low holds the pipe).
// Reset: soc = 1.0, previous current = 0, held pair = lowest bin, ms mode.
// Stall: each stage advances when its successor has room, so bubbles close up
//   while m_ready is low; s_ready drops only once all ten stages are full.
module battery_soc_coulomb_gauge_core #(
    parameter int CURRENT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [CURRENT_BITS-1:0] s_current_ma,
    input  logic [15:0]                    s_elapsed,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_soc_level,
    output logic [14:0]                    m_voc_mv,
    output logic [14:0]                    m_rs_micro_ohm,
    output logic                           m_depleted
);

    localparam int SW = CURRENT_BITS + 1;   // current + previous current
    localparam int PW = CURRENT_BITS + 9;   // signed product with dt
    localparam int MW = CURRENT_BITS + 7;   // |product| <= 2^CURRENT_BITS * 99
    localparam int XW = (MW + 10 > int'(bscg_pkg::YW) + 1) ? MW + 10 : int'(bscg_pkg::YW) + 1;
    localparam int NS = 10;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic time_in_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_in_ms_reg <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2:2] == bscg_pkg::REG_TIME_IN_MS)) begin
            time_in_ms_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == bscg_pkg::REG_TIME_IN_MS) ? {31'd0, time_in_ms_reg} : 32'd0;

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads.
    // ---------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NS-1];

    // ---------------------------------------------------------------
    // Stage 0: trapezoid sum and gated dt. Previous current updates on accept.
    // ---------------------------------------------------------------
    logic signed [CURRENT_BITS-1:0] last_current_reg;
    logic signed [SW-1:0]           sum0_reg, sum0_next;
    logic [bscg_pkg::DT_W-1:0]      dt0_reg, dt0_next;

    always_comb begin
        sum0_next = SW'(s_current_ma) + SW'(last_current_reg);
        dt0_next  = (s_elapsed < bscg_pkg::GAP_LIMIT) ? s_elapsed[bscg_pkg::DT_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_current_reg <= '0;
        end else if (s_valid && stage_en[0]) begin
            last_current_reg <= s_current_ma;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sum0_reg <= sum0_next;
            dt0_reg  <= dt0_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: charge moved = sum * dt, split into sign and magnitude
    // ---------------------------------------------------------------
    logic signed [PW-1:0] prod1;
    logic signed [PW-1:0] abs1;
    logic                 neg1_reg, neg1_next;
    logic [MW-1:0]        mag1_reg, mag1_next;

    always_comb begin
        prod1     = PW'(sum0_reg) * $signed({{(PW - int'(bscg_pkg::DT_W)){1'b0}}, dt0_reg});
        neg1_next = prod1[PW-1];
        abs1      = neg1_next ? -prod1 : prod1;
        mag1_next = abs1[MW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            neg1_reg <= neg1_next;
            mag1_reg <= mag1_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: bring seconds onto the ms divisor, saturate the numerator
    // ---------------------------------------------------------------
    logic [XW-1:0]             mag2_ext, mag2_scaled, y2_raw;
    logic                      neg2_reg;
    logic [bscg_pkg::YW-1:0]   y2_reg, y2_next;

    always_comb begin
        mag2_ext    = XW'(mag1_reg);
        mag2_scaled = mag2_ext * XW'(bscg_pkg::SCALE_MS);
        y2_raw      = time_in_ms_reg ? mag2_ext : mag2_scaled;
        y2_next     = (y2_raw > XW'(bscg_pkg::Y_CAP)) ? bscg_pkg::Y_CAP
                                                       : y2_raw[bscg_pkg::YW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            neg2_reg <= neg1_reg;
            y2_reg   <= y2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: reciprocal multiply, two half-width partial products
    // ---------------------------------------------------------------
    logic                      neg3_reg;
    logic [bscg_pkg::PPW-1:0]  pplo3_reg, pplo3_next;
    logic [bscg_pkg::PPW-1:0]  pphi3_reg, pphi3_next;
    logic [bscg_pkg::YLW-1:0]  ylo3_reg;

    always_comb begin
        pplo3_next = bscg_pkg::PPW'(y2_reg[bscg_pkg::YH-1:0]) * bscg_pkg::PPW'(bscg_pkg::DIV_M);
        pphi3_next = bscg_pkg::PPW'(y2_reg[bscg_pkg::YW-1:bscg_pkg::YH])
                   * bscg_pkg::PPW'(bscg_pkg::DIV_M);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            neg3_reg  <= neg2_reg;
            pplo3_reg <= pplo3_next;
            pphi3_reg <= pphi3_next;
            ylo3_reg  <= y2_reg[bscg_pkg::YLW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: combine partial products; estimate is q or q-1
    // ---------------------------------------------------------------
    logic [bscg_pkg::FW-1:0]   full4;
    logic                      neg4_reg;
    logic [bscg_pkg::QW-1:0]   q04_reg, q04_next;
    logic [bscg_pkg::YLW-1:0]  ylo4_reg;

    always_comb begin
        full4    = bscg_pkg::FW'(pplo3_reg) + (bscg_pkg::FW'(pphi3_reg) << bscg_pkg::YH);
        q04_next = full4[bscg_pkg::FW-1:bscg_pkg::DIV_SH];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            neg4_reg <= neg3_reg;
            q04_reg  <= q04_next;
            ylo4_reg <= ylo3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: remainder y*2^20 - q0*D, only its low bits matter
    // ---------------------------------------------------------------
    logic [bscg_pkg::RW-1:0]   qd5;
    logic                      neg5_reg;
    logic [bscg_pkg::QW-1:0]   q05_reg;
    logic [bscg_pkg::RW-1:0]   rem5_reg, rem5_next;

    always_comb begin
        qd5       = bscg_pkg::RW'(q04_reg[bscg_pkg::RW-1:0]) * bscg_pkg::RW'(bscg_pkg::DIV_D);
        rem5_next = {ylo4_reg, {bscg_pkg::REM_SH{1'b0}}} - qd5;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            neg5_reg <= neg4_reg;
            q05_reg  <= q04_reg;
            rem5_reg <= rem5_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: correction step
    // ---------------------------------------------------------------
    logic                      neg6_reg;
    logic [bscg_pkg::QW-1:0]   q6_reg, q6_next;

    always_comb begin
        q6_next = q05_reg + bscg_pkg::QW'(rem5_reg >= bscg_pkg::RW'(bscg_pkg::DIV_D));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            neg6_reg <= neg5_reg;
            q6_reg   <= q6_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: accumulate into soc with clamp at 1.0 and -2^31
    // ---------------------------------------------------------------
    logic signed [bscg_pkg::SOC_W-1:0] charge_level_reg;
    logic signed [bscg_pkg::ACW-1:0]   acc7_c, acc7_q, acc7_sum;
    logic signed [bscg_pkg::SOC_W-1:0] soc7_reg, soc7_next;
    logic                              charge_ld;

    always_comb begin
        acc7_c   = bscg_pkg::ACW'(charge_level_reg);
        acc7_q   = $signed(bscg_pkg::ACW'(q6_reg));
        // a negative step (charging) adds its magnitude
        acc7_sum = neg6_reg ? (acc7_c + acc7_q) : (acc7_c - acc7_q);
        if (acc7_sum > bscg_pkg::ACW'(bscg_pkg::Q_ONE)) begin
            soc7_next = bscg_pkg::Q_ONE;
        end else if (acc7_sum < bscg_pkg::ACW'(bscg_pkg::SOC_MIN)) begin
            soc7_next = bscg_pkg::SOC_MIN;
        end else begin
            soc7_next = bscg_pkg::SOC_W'(acc7_sum);
        end
    end

    assign charge_ld = stage_en[7] && valid_reg[6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_level_reg <= bscg_pkg::Q_ONE;
        end else if (charge_ld) begin
            charge_level_reg <= soc7_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            soc7_reg <= soc7_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: bin index = (floor(40*soc / 2^30) + 1) / 2, capped at 20
    // ---------------------------------------------------------------
    logic [36:0]                 x40_8;
    logic [6:0]                  t8;
    logic [7:0]                  binw8;
    logic signed [31:0]          soc8_reg;
    bscg_pkg::bin_idx_t          bin8_reg, bin8_next;
    logic                        nonneg8_reg;

    always_comb begin
        x40_8     = (37'(soc7_reg[30:0]) << 5) + (37'(soc7_reg[30:0]) << 3);
        t8        = x40_8[36:30];
        binw8     = ({1'b0, t8} + 8'd1) >> 1;
        bin8_next = (binw8 > 8'(bscg_pkg::BIN_LAST)) ? bscg_pkg::BIN_LAST
                                                    : binw8[bscg_pkg::BIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            soc8_reg    <= soc7_reg;
            bin8_reg    <= bin8_next;
            nonneg8_reg <= !soc7_reg[31];
        end
    end

    // ---------------------------------------------------------------
    // Stage 9: table lookup, hold on negative soc, result register
    // ---------------------------------------------------------------
    logic signed [31:0]       m_soc_level_reg;
    bscg_pkg::table_val_t     m_voc_mv_reg;
    bscg_pkg::table_val_t     m_rs_micro_ohm_reg;
    logic                     m_depleted_reg;
    logic                     out_ld;

    assign out_ld = stage_en[9] && valid_reg[8];

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_soc_level_reg <= soc8_reg;
            m_depleted_reg  <= soc8_reg[31] || (soc8_reg == 32'sd0);
        end
    end

    // the result register also holds the last valid pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_voc_mv_reg       <= bscg_pkg::VOC_RESET;
            m_rs_micro_ohm_reg <= bscg_pkg::RS_RESET;
        end else if (out_ld && nonneg8_reg) begin
            m_voc_mv_reg       <= bscg_pkg::voc_of(bin8_reg);
            m_rs_micro_ohm_reg <= bscg_pkg::rs_of(bin8_reg);
        end
    end

    assign m_soc_level    = m_soc_level_reg;
    assign m_voc_mv       = m_voc_mv_reg;
    assign m_rs_micro_ohm = m_rs_micro_ohm_reg;
    assign m_depleted     = m_depleted_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_dep_matches_soc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_depleted == (m_soc_level <= 32'sd0)))
        else $error("depleted flag disagrees with soc sign");

    a_soc_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_soc_level <= bscg_pkg::Q_ONE))
        else $error("soc above 1.0 on output");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&valid_reg) && !m_ready))
        else $error("input stalled with room in the pipeline");

    a_charge_tracks_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        charge_ld |=> (charge_level_reg == soc7_reg))
        else $error("charge state differs from item soc");

endmodule

/* tb/tb.sv */
// Self-checking testbench for battery_soc_coulomb_gauge_core.
// Predicts every reading of the fuel gauge in SV and checks it against the result channel.
// Depends on bscg_pkg (register index) and the gauge RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CUR_W = 16;

    // Register map: byte address is four times the register index. The second
    // word has no register behind it, so a write there must change nothing.
    localparam logic [2:0] ADDR_TIME_MODE = {bscg_pkg::REG_TIME_IN_MS, 2'b00};
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;
    localparam logic       MODE_SECONDS   = 1'b0;
    localparam logic       MODE_MS        = 1'b1;

    localparam logic signed [15:0] CUR_MAX = 16'sh7FFF;
    localparam logic signed [15:0] CUR_MIN = 16'sh8000;

    // gauge constants, Q2.30
    localparam longint GAP_TICKS   = 100;
    localparam longint Q_FULL      = 64'sh0000_0000_4000_0000;
    localparam longint SOC_FLOOR   = 64'shFFFF_FFFF_8000_0000;
    localparam longint DIV_SECONDS = 64'd10800000;
    localparam longint DIV_MS      = 64'd10800000000;
    localparam int     BIN_TOP     = 20;

    localparam int unsigned PIPE_SETTLE  = 14;     // ten-stage pipe plus margin
    localparam int unsigned DRAIN_CAP    = 100000; // cycles allowed for one phase to drain
    localparam int          RUN_LIMIT_NS = 20_000_000;

    typedef enum int unsigned {HEAD_DISCHARGE, HEAD_CHARGE, HEAD_MIXED} heading_t;

    typedef struct {
        logic signed [15:0] current_ma;
        logic [15:0]        elapsed;
    } sample_t;

    typedef struct {
        logic signed [31:0] soc;
        logic [14:0]        voc;
        logic [14:0]        rs;
        logic               depleted;
    } reading_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // DUT ports, every input known from time zero
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [2:0]              paddr   = '0;
    logic [31:0]             pwdata  = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic signed [CUR_W-1:0] s_current_ma = '0;
    logic [15:0]             s_elapsed    = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic signed [31:0]      m_soc_level;
    logic [14:0]             m_voc_mv;
    logic [14:0]             m_rs_micro_ohm;
    logic                    m_depleted;

    battery_soc_coulomb_gauge_core #(
        .CURRENT_BITS(CUR_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_current_ma  (s_current_ma),
        .s_elapsed     (s_elapsed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_soc_level   (m_soc_level),
        .m_voc_mv      (m_voc_mv),
        .m_rs_micro_ohm(m_rs_micro_ohm),
        .m_depleted    (m_depleted)
    );

    // Bin tables: six-cell open-circuit voltage (mV) and series resistance (uOhm)
    logic [14:0] voc_by_bin [0:20] = '{
        15'd15000, 15'd17721, 15'd18612, 15'd19371, 15'd20015, 15'd20389, 15'd20704,
        15'd20968, 15'd21225, 15'd21562, 15'd21892, 15'd22202, 15'd22477, 15'd22750,
        15'd22995, 15'd23315, 15'd23617, 15'd23834, 15'd23894, 15'd24067, 15'd25200
    };
    logic [14:0] rs_by_bin [0:20] = '{
        15'd18500, 15'd18500, 15'd16700, 15'd16500, 15'd18200, 15'd18000, 15'd18700,
        15'd18800, 15'd19100, 15'd20300, 15'd21400, 15'd22400, 15'd22800, 15'd23400,
        15'd23600, 15'd24600, 15'd25700, 15'd25600, 15'd24300, 15'd23900, 15'd23900
    };

    // Gauge state as the testbench tracks it (reset values of the block)
    logic               ms_mode  = MODE_MS;
    logic signed [31:0] soc_q30  = 32'sh4000_0000;
    logic signed [15:0] prev_ma  = '0;
    logic [14:0]        held_voc = 15'd15000;
    logic [14:0]        held_rs  = 15'd18500;

    sample_t  sample_q[$];   // items waiting for the driver
    reading_t reading_q[$];  // predicted readings, oldest first

    int unsigned s_idle_max = 0;
    int unsigned m_idle_max = 0;
    int unsigned s_gap      = 0;
    int unsigned m_hold     = 0;
    logic        s_took     = 1'b0;
    logic        m_took     = 1'b0;

    int unsigned fails            = 0;
    int unsigned readings_checked = 0;
    int unsigned depleted_seen    = 0;
    int unsigned full_clamps      = 0;
    int unsigned floor_hits       = 0;
    logic [20:0] bins_seen        = '0;

    // One coulomb-counting update. The step is
    //   trunc((i + i_prev) * dt * 2^30 / (10800 * 1000 * scale)),
    // with no trapezoid halving; dt of 100 or more is a long gap and counts as 0.
    task automatic coulomb_step(input logic signed [15:0] cur, input logic [15:0] el,
                                output reading_t rd);
        longint dt, prod, mag, q, divisor, nxt, bin_idx;
        dt      = (el >= GAP_TICKS) ? 64'sd0 : longint'(el);
        prod    = (longint'(cur) + longint'(prev_ma)) * dt;
        mag     = (prod < 0) ? -prod : prod;
        divisor = ms_mode ? DIV_MS : DIV_SECONDS;
        q       = (mag << 30) / divisor;
        // a negative product is charge flowing in
        nxt = (prod < 0) ? longint'(soc_q30) + q : longint'(soc_q30) - q;
        if (nxt > Q_FULL) begin
            nxt = Q_FULL;
            full_clamps++;
        end
        if (nxt < SOC_FLOOR) begin
            nxt = SOC_FLOOR;
            floor_hits++;
        end
        soc_q30 = nxt[31:0];
        prev_ma = cur;
        // bins are centered on multiples of 1/20; below zero the pair holds
        if (nxt >= 0) begin
            bin_idx = (40 * nxt + Q_FULL) / (2 * Q_FULL);
            if (bin_idx > BIN_TOP)
                bin_idx = BIN_TOP;
            held_voc = voc_by_bin[bin_idx];
            held_rs  = rs_by_bin[bin_idx];
            bins_seen[bin_idx] = 1'b1;
        end
        rd.soc      = soc_q30;
        rd.voc      = held_voc;
        rd.rs       = held_rs;
        rd.depleted = (nxt <= 0);
    endtask

    // Sender: changes at the falling edge, holds the item until it is taken,
    // then idles for the gap drawn when the item went out.
    always @(negedge aclk) begin : sender
        sample_t smp;
        if (aresetn && !(s_valid && !s_took)) begin
            if (s_gap != 0) begin
                s_valid <= 1'b0;
                s_gap   <= s_gap - 1;
            end else if (sample_q.size() != 0) begin
                smp = sample_q.pop_front();
                s_valid      <= 1'b1;
                s_current_ma <= smp.current_ma;
                s_elapsed    <= smp.elapsed;
                s_gap        <= $urandom_range(0, s_idle_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: after each taken reading, drop m_ready for a drawn stall.
    always @(negedge aclk) begin : receiver
        int unsigned w;
        w = m_took ? $urandom_range(0, m_idle_max) : m_hold;
        if (w != 0) begin
            m_ready <= 1'b0;
            m_hold  <= w - 1;
        end else begin
            m_ready <= 1'b1;
            m_hold  <= 0;
        end
    end

    // Both handshakes are observed at the rising edge. The result check runs
    // before the new prediction is queued so a stray result cannot match it.
    always @(posedge aclk) begin : scoreboard
        reading_t got, want, predicted;
        s_took <= aresetn && s_valid && s_ready;
        m_took <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_soc_level, m_voc_mv, m_rs_micro_ohm, m_depleted};
            if (reading_q.size() == 0) begin
                $error("reading arrived with no item outstanding");
                fails++;
            end else begin
                want = reading_q.pop_front();
                readings_checked++;
                if (got.soc !== want.soc) begin
                    $error("soc_level: expected %0d, got %0d", want.soc, got.soc);
                    fails++;
                end
                if (got.voc !== want.voc) begin
                    $error("voc_mv: expected %0d, got %0d", want.voc, got.voc);
                    fails++;
                end
                if (got.rs !== want.rs) begin
                    $error("rs_micro_ohm: expected %0d, got %0d", want.rs, got.rs);
                    fails++;
                end
                if (got.depleted !== want.depleted) begin
                    $error("depleted: expected %0b, got %0b", want.depleted, got.depleted);
                    fails++;
                end
                if (want.depleted)
                    depleted_seen++;
            end
        end
        if (aresetn && s_valid && s_ready) begin
            coulomb_step(s_current_ma, s_elapsed, predicted);
            reading_q.push_back(predicted);
        end
    end

    // APB write: setup cycle, then access until pready. Only the mode word is real.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_TIME_MODE)
            ms_mode = data[0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read of the mode word, checked against the tracked setting
    task automatic check_mode_reg;
        logic [31:0] rd;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TIME_MODE;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (rd !== 32'(ms_mode)) begin
            $error("time_in_ms readback: expected %0d, got %0d", ms_mode, rd);
            fails++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_sample(input logic signed [15:0] cur, input logic [15:0] el);
        sample_t smp;
        smp.current_ma = cur;
        smp.elapsed    = el;
        sample_q.push_back(smp);
    endtask

    // Wait until every queued item has produced its reading,
    // then let the pipe settle so the gauge is idle for a register write.
    task automatic drain_readings;
        int unsigned n;
        n = 0;
        while ((sample_q.size() != 0 || s_valid || reading_q.size() != 0) && n < DRAIN_CAP) begin
            @(posedge aclk);
            n++;
        end
        if (reading_q.size() != 0) begin
            $error("%0d readings never arrived", reading_q.size());
            fails++;
            reading_q.delete();
        end
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Random traffic as bursts of a steady discharge, charge or mixed load with a
    // random magnitude class, so the charge walks through the bins, past full and
    // below zero. About one item in eight is raw noise on both fields, and about
    // one in ten of the rest is a long gap.
    task automatic add_bursts(input int unsigned count);
        int unsigned done, len, mag;
        heading_t    heading;
        logic [15:0] cur, el;
        done = 0;
        while (done < count) begin
            len     = $urandom_range(4, 40);
            heading = heading_t'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0:       mag = 300;
                1:       mag = 3000;
                default: mag = 32767;
            endcase
            repeat (len) begin
                if ($urandom_range(0, 7) == 0) begin
                    cur = 16'($urandom);
                    el  = 16'($urandom);
                end else begin
                    cur = 16'($urandom_range(0, mag));
                    if (heading == HEAD_CHARGE || (heading == HEAD_MIXED && $urandom_range(0, 1)))
                        cur = -cur;
                    if ($urandom_range(0, 9) == 0)
                        el = 16'($urandom_range(100, 65535));
                    else
                        el = 16'($urandom_range(0, 99));
                end
                add_sample(cur, el);
                done++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Millisecond mode out of reset: field extremes, long gaps at 100 and
        // at the top of the elapsed range, the largest in-range elapsed time.
        check_mode_reg();
        s_idle_max = 3;
        m_idle_max = 3;
        add_sample(CUR_MAX, 16'd0);
        add_sample(CUR_MIN, 16'd0);
        add_sample(CUR_MAX, 16'd100);
        add_sample(CUR_MIN, 16'hFFFF);
        add_sample(CUR_MAX, 16'd99);
        add_sample(CUR_MIN, 16'd99);
        drain_readings();

        // Seconds mode, where one item moves the charge by up to 0.6.
        apb_write(ADDR_TIME_MODE, 32'(MODE_SECONDS));
        check_mode_reg();
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        check_mode_reg();
        // full charge current twice: overcharge clamps to exactly 1.0
        add_sample(CUR_MIN, 16'd99);
        add_sample(CUR_MIN, 16'd99);
        // (28125 + 28125) * 96 is exactly half the seconds divisor scaled, so two
        // such steps from 1.0 land on zero: lowest bin and depleted
        add_sample(16'sd0, 16'd0);
        add_sample(16'sd28125, 16'd0);
        add_sample(16'sd28125, 16'd96);
        add_sample(16'sd28125, 16'd96);
        // deep discharge saturates at the floor
        repeat (5) add_sample(CUR_MAX, 16'd99);
        // climb back into a middle bin, then fall below zero: the pair holds
        repeat (5) add_sample(CUR_MIN, 16'd99);
        add_sample(CUR_MAX, 16'd99);
        add_sample(CUR_MAX, 16'd99);
        drain_readings();

        // random traffic, seconds mode, idling on both sides
        s_idle_max = 14;
        m_idle_max = 14;
        add_bursts(500);
        drain_readings();

        // milliseconds, back to back with no idling
        apb_write(ADDR_TIME_MODE, 32'(MODE_MS));
        check_mode_reg();
        s_idle_max = 0;
        m_idle_max = 0;
        add_bursts(300);
        drain_readings();

        // seconds, sender flat out against a stalling receiver: pipe fills up
        apb_write(ADDR_TIME_MODE, 32'(MODE_SECONDS));
        check_mode_reg();
        s_idle_max = 0;
        m_idle_max = 14;
        add_bursts(350);
        drain_readings();

        // milliseconds, sparse sender and an always-ready receiver
        apb_write(ADDR_TIME_MODE, 32'(MODE_MS));
        check_mode_reg();
        s_idle_max = 14;
        m_idle_max = 0;
        add_bursts(250);
        drain_readings();

        $display("Gauge run: %0d readings checked in both time modes, %0d of 21 bins visited",
                 readings_checked, $countones(bins_seen));
        $display("  %0d depleted readings, %0d clamps at full, %0d saturations at the floor",
                 depleted_seen, full_clamps, floor_hits);
        if (fails == 0) begin
            $display("[battery_soc_coulomb_gauge_core] OK");
        end else begin
            $display("[battery_soc_coulomb_gauge_core] ERROR");
        end
        $finish;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[battery_soc_coulomb_gauge_core] ERROR");
        $finish;
    end

endmodule
